// ===== hdl/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and codes for the ordered sequence table and its cells.
// ----------------------------------------------------------------------------
package ost_pkg;

	// wide enough for any cell index or count up to 4096
	localparam int IDX_W = 13;

	typedef enum logic [2:0] {
		MODE_INSERT_AT     = 3'd0,
		MODE_INSERT_SORTED = 3'd1,
		MODE_ERASE_AT      = 3'd2,
		MODE_REMOVE_EQUAL  = 3'd3,
		MODE_GET           = 3'd4,
		MODE_SET           = 3'd5,
		MODE_FIND          = 3'd6,
		MODE_UNUSED        = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_APPLY
	} state_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_OPEN,
		CMD_CLOSE,
		CMD_WRITE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  pos;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [6:0]  position;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic signed [7:0] index_out;
		logic [31:0]       read_value;
		logic [6:0]        removed_count;
		logic [6:0]        entry_count;
	} res_t;

	localparam logic signed [7:0] NO_INDEX = -8'sd1;

endpackage

// ===== hdl/ordered_sequence_table.sv =====
// ----------------------------------------------------------------------------
// ordered_sequence_table
// Ordered list of up to DEPTH values held in a row of cells; an insert or erase
// shifts the cells from its position on at once, and set rewrites one cell.
// ----------------------------------------------------------------------------
// channel  | handshake      | payload
// request  | start / busy   | req  (mode, position, item_value)
// result   | done strobe    | res  (ok, index_out, read_value, removed_count,
//          |                |       entry_count)
//
// a request goes from accept to the done strobe through the states EVAL and
// APPLY: it is latched on accept, the cells register their compare flags in
// EVAL, and APPLY carries it out; remove_equal repeats EVAL and APPLY once
// per removed element, and a last pass that finds no match reports the result
// busy is high from the beat after accept until the result is registered
// reset empties the list; cell contents are left as they are
// ----------------------------------------------------------------------------
module ordered_sequence_table
	import ost_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int WW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	state_t                 state_q, state_d;
	logic [2:0]             mode_q;
	logic [6:0]             pos_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          removed_q, removed_d;
	logic                   done_q, done_d;
	res_t                   res_q, res_d;
	cell_cmd_t              cmd;

	logic [VALUE_WIDTH-1:0] elem [DEPTH];
	logic [DEPTH-1:0]       eq_v, gt_v, hit_eq, hit_gt;
	logic                   any_eq, any_gt;
	logic [CW-1:0]          first_eq, first_gt;
	logic [WW-1:0]          posx, cntx;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [VALUE_WIDTH-1:0] lft, rgt;
			if (g == 0) begin : g_first
				assign lft = '0;
			end else begin : g_mid_l
				assign lft = elem[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign rgt = '0;
			end else begin : g_mid_r
				assign rgt = elem[g+1];
			end
			ost_cell #(.IDX(g), .VW(VALUE_WIDTH)) u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.key   (key_q),
				.left  (lft),
				.right (rgt),
				.elem  (elem[g]),
				.eq    (eq_v[g]),
				.gt    (gt_v[g])
			);
			assign hit_eq[g] = eq_v[g] && (CW'(g) < count_q);
			assign hit_gt[g] = gt_v[g] && (CW'(g) < count_q);
		end
	endgenerate

	// first live cell holding an equal value, and first live cell holding a greater value
	always_comb begin
		any_eq   = 1'b0;
		any_gt   = 1'b0;
		first_eq = '0;
		first_gt = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (hit_eq[k]) begin
				any_eq   = 1'b1;
				first_eq = CW'(k);
			end
			if (hit_gt[k]) begin
				any_gt   = 1'b1;
				first_gt = CW'(k);
			end
		end
	end

	assign posx = WW'(pos_q);
	assign cntx = WW'(count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_APPLY;
			ST_APPLY: begin
				if (mode_q == MODE_REMOVE_EQUAL && any_eq) state_d = ST_EVAL;
				else state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '{kind: CMD_HOLD, pos: '0};
		count_d   = count_q;
		removed_d = removed_q;
		done_d    = 1'b0;
		res_d     = '{ok: 1'b0, index_out: NO_INDEX, read_value: '0,
		              removed_count: '0, entry_count: '0};
		if (state_q == ST_IDLE && start) removed_d = '0;
		if (state_q == ST_APPLY) begin
			done_d = 1'b1;
			unique case (mode_q)
				MODE_INSERT_AT: begin
					if (posx <= cntx && count_q != FULL) begin
						cmd       = '{kind: CMD_OPEN, pos: IDX_W'(pos_q)};
						count_d   = count_q + 1'b1;
						res_d.ok  = 1'b1;
					end
				end
				MODE_INSERT_SORTED: begin
					if (count_q != FULL) begin
						cmd = '{kind: CMD_OPEN,
						        pos: IDX_W'(any_gt ? first_gt : count_q)};
						count_d         = count_q + 1'b1;
						res_d.ok        = 1'b1;
						res_d.index_out = 8'(any_gt ? first_gt : count_q);
					end
				end
				MODE_ERASE_AT: begin
					if (posx < cntx) begin
						cmd      = '{kind: CMD_CLOSE, pos: IDX_W'(pos_q)};
						count_d  = count_q - 1'b1;
						res_d.ok = 1'b1;
					end
				end
				MODE_REMOVE_EQUAL: begin
					if (any_eq) begin
						// drop one match per pass until none is left
						cmd       = '{kind: CMD_CLOSE, pos: IDX_W'(first_eq)};
						count_d   = count_q - 1'b1;
						removed_d = removed_q + 1'b1;
						done_d    = 1'b0;
					end else begin
						res_d.ok            = 1'b1;
						res_d.removed_count = 7'(removed_q);
					end
				end
				MODE_GET: begin
					if (posx < cntx) begin
						res_d.ok         = 1'b1;
						res_d.read_value = 32'(elem[posx[IW-1:0]]);
					end
				end
				MODE_SET: begin
					if (posx < cntx) begin
						cmd      = '{kind: CMD_WRITE, pos: IDX_W'(pos_q)};
						res_d.ok = 1'b1;
					end
				end
				MODE_FIND: begin
					res_d.ok = 1'b1;
					if (any_eq) res_d.index_out = 8'(first_eq);
				end
				default: begin
				end
			endcase
			res_d.entry_count = 7'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= req.mode;
			pos_q  <= req.position;
			key_q  <= VALUE_WIDTH'(req.item_value);
		end
		if (done_d) res_q <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("element count beyond depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result beat while still working");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == ST_EVAL)
		else $error("accepted request not evaluated");

	a_count_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> res_q.entry_count == 7'(count_q))
		else $error("reported count differs from stored count");

endmodule

// ===== hdl/ost_cell.sv =====
// ----------------------------------------------------------------------------
// ost_cell
// One element slot: holds a value, shifts to or from its neighbours and
// registers its compare flags against the search key.
// ----------------------------------------------------------------------------
module ost_cell
	import ost_pkg::*;
#(
	parameter int IDX = 0,
	parameter int VW  = 32
) (
	input  logic          clk,
	input  cell_cmd_t     cmd,
	input  logic [VW-1:0] key,
	input  logic [VW-1:0] left,
	input  logic [VW-1:0] right,
	output logic [VW-1:0] elem,
	output logic          eq,
	output logic          gt
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [VW-1:0] elem_q;
	logic          eq_q;
	logic          gt_q;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_OPEN: begin
				if (MY_IDX == cmd.pos) elem_q <= key;
				else if (MY_IDX > cmd.pos) elem_q <= left;
			end
			CMD_CLOSE: begin
				if (MY_IDX >= cmd.pos) elem_q <= right;
			end
			CMD_WRITE: begin
				if (MY_IDX == cmd.pos) elem_q <= key;
			end
			default: begin
			end
		endcase
		eq_q <= (elem_q == key);
		gt_q <= (elem_q > key);
	end

	assign elem = elem_q;
	assign eq   = eq_q;
	assign gt   = gt_q;

endmodule
